/* rtl/keypad_code_lock_assert.svh */
// Assertion macros for the keypad code lock checker.
// No dependencies; included by the checker file only.
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// Checked while out of reset.
`define KCL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define KCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/kcl_pkg.sv */
// Shared types and constants for the keypad code lock.
// No dependencies; imported by every module of the block.
package kcl_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
  localparam int IDLE_W      = 17;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  localparam int MAX_RESULTS = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W   = 2;

  localparam logic       CMD_KEY       = 1'b0;
  localparam logic       CMD_TICK      = 1'b1;
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  localparam logic [15:0] CODE_RESET    = 16'h1234;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_TIMEOUT = 3'd2,
    EV_OK      = 3'd3,
    EV_BAD     = 3'd4
  } kcl_event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE    = 2'd0,
    CFG_TIMEOUT = 2'd1
  } kcl_cfg_idx_e;

  typedef struct packed {
    logic       cmd;
    logic [3:0] key_code;
  } kcl_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] shown_digits;
    logic [2:0]  entered_count;
    logic        last_of_run;
  } kcl_out_t;

  typedef struct packed {
    logic [15:0] code_value;
    logic [15:0] timeout_ticks;
  } kcl_cfg_t;

  // results produced by one item, res_a first
  typedef struct packed {
    logic [1:0] num;
    kcl_out_t   res_a;
    kcl_out_t   res_b;
  } kcl_push_t;

endpackage

/* rtl/kcl_cfg.sv */
// Configuration registers of the keypad code lock.
// Depends on kcl_pkg.
module kcl_cfg import kcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output kcl_cfg_t             cfg_o
);

  kcl_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CODE:    cfg_d.code_value    = cfg_data_i;
        CFG_TIMEOUT: cfg_d.timeout_ticks = cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_value    <= CODE_RESET;
      cfg_q.timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/kcl_core.sv */
// Entry state and per-item decision logic of the keypad code lock.
// Depends on kcl_pkg; feeds kcl_outq with up to two results per item.
module kcl_core import kcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  kcl_in_t   item_i,
  input  kcl_cfg_t  cfg_i,
  output kcl_push_t push_o
);

  typedef logic [CODE_LENGTH-1:0][3:0] digits_t;

  logic              active_q, active_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  digits_t           dig_q, dig_d, dig_new;
  logic [IDLE_W-1:0] idle_q, idle_d, idle_inc;
  logic              match;
  logic              is_entry_key;

  function automatic logic [15:0] shown(input digits_t d);
    logic [15:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CODE_LENGTH) v[15-4*i -: 4] = d[i];
    end
    return v;
  endfunction

  always_comb begin
    idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
    cnt_inc  = cnt_q + 1'b1;
    dig_new  = dig_q;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (CNT_W'(i) == cnt_q) dig_new[i] = item_i.key_code;
    end
    // positions past the fourth expect zero
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (i < 4) begin
        if (dig_new[i] != cfg_i.code_value[15-4*(i%4) -: 4]) match = 1'b0;
      end else if (dig_new[i] != 4'd0) begin
        match = 1'b0;
      end
    end
    is_entry_key = (item_i.key_code == KEY_STAR) || (item_i.key_code == KEY_HASH);
  end

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    dig_d    = dig_q;
    idle_d   = idle_q;
    push_o   = '0;
    if (accept_i) begin
      if (item_i.cmd == CMD_TICK) begin
        if (active_q) begin
          idle_d = idle_inc;
          if (idle_inc > {1'b0, cfg_i.timeout_ticks}) begin
            active_d = 1'b0;
            cnt_d    = '0;
            dig_d    = '0;
            idle_d   = '0;
            push_o.num                 = 2'd1;
            push_o.res_a.event_res     = EV_TIMEOUT;
            push_o.res_a.last_of_run   = 1'b1;
          end
        end
      end else if (is_entry_key) begin
        active_d = 1'b1;
        cnt_d    = '0;
        dig_d    = '0;
        idle_d   = '0;
        push_o.num               = 2'd1;
        push_o.res_a.event_res   = EV_START;
        push_o.res_a.last_of_run = 1'b1;
      end else if (item_i.key_code <= KEY_DIGIT_MAX && active_q &&
                   cnt_q < CNT_W'(CODE_LENGTH)) begin
        cnt_d  = cnt_inc;
        dig_d  = dig_new;
        idle_d = '0;
        push_o.num                 = 2'd1;
        push_o.res_a.event_res     = EV_DIGIT;
        push_o.res_a.shown_digits  = shown(dig_new);
        push_o.res_a.entered_count = 3'(cnt_inc);
        push_o.res_a.last_of_run   = 1'b1;
        if (cnt_inc == CNT_W'(CODE_LENGTH)) begin
          // code complete: verdict follows with an empty buffer
          active_d = 1'b0;
          cnt_d    = '0;
          dig_d    = '0;
          push_o.num                = 2'd2;
          push_o.res_a.last_of_run  = 1'b0;
          push_o.res_b.event_res    = match ? EV_OK : EV_BAD;
          push_o.res_b.last_of_run  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      dig_q    <= '0;
      idle_q   <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      dig_q    <= dig_d;
      idle_q   <= idle_d;
    end
  end

endmodule

/* rtl/kcl_outq.sv */
// Result queue of the keypad code lock: takes up to two results a cycle,
// hands out one a cycle while out_ready_i is high. Depends on kcl_pkg.
module kcl_outq import kcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kcl_push_t push_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output kcl_out_t  out_data_o
);

  kcl_out_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of one item
  assign space_o     = (cnt_q <= QCNT_W'(QDEPTH - MAX_RESULTS));

  always_comb begin
    wr_d  = wr_q + QPTR_W'(push_i.num);
    rd_d  = rd_q + QPTR_W'(pop);
    cnt_d = cnt_q + QCNT_W'(push_i.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.res_a;
    if (push_i.num == 2'd2) mem_q[QPTR_W'(wr_q + 1'b1)] <= push_i.res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/keypad_code_lock.sv */
// Keypad code lock, top level.
// Depends on kcl_pkg, kcl_cfg, kcl_core and kcl_outq.
//
//  channel | signals                                    | dir
//  --------+--------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, in_data_i           | in
//  out     | out_valid_o, out_ready_i, out_data_o        | out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data  | in
//
// An item is decided in the cycle it is accepted; its results, if any,
// appear from the next cycle through a four-entry queue, one per cycle
// while taken. Sustained rate is one item per cycle while results are
// taken; in_ready_o drops while the queue could not hold two more results.
// Reset clears entry state and sets the code to 1234, timeout to 3000.
// Config writes are always taken; indexes beyond the list are dropped.
module keypad_code_lock import kcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kcl_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kcl_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  kcl_cfg_t  cfg;
  kcl_push_t push;
  logic      accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  kcl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .push_o   (push)
  );

  kcl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/kcl_checker.sv */
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock_assert.svh.
`include "keypad_code_lock_assert.svh"

module kcl_assert_checker import kcl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input kcl_out_t out_data_o
);

  logic verdict, restart_or_timeout;
  logic out_stall, buf_clear, open_digit, full_count;

  assign verdict = out_data_o.event_res == EV_OK || out_data_o.event_res == EV_BAD;
  assign restart_or_timeout = out_data_o.event_res == EV_START ||
                              out_data_o.event_res == EV_TIMEOUT;
  assign out_stall  = out_valid_o && !out_ready_i;
  // empty buffer and the closing result of its item
  assign buf_clear  = out_data_o.shown_digits == 16'd0 && out_data_o.entered_count == 3'd0 &&
                      out_data_o.last_of_run;
  assign open_digit = out_data_o.event_res == EV_DIGIT && !out_data_o.last_of_run;
  assign full_count = out_data_o.entered_count == 3'(CODE_LENGTH);

  // a waiting item holds
  `KCL_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o), "stall broken")
  // verdict shows an empty buffer and closes the run
  `KCL_ASSERT(a_verdict_clear, clk_i, rst_ni, out_valid_o && verdict |-> buf_clear, "verdict with digits")
  // start and timeout are single results with an empty buffer
  `KCL_ASSERT(a_single_clear, clk_i, rst_ni, out_valid_o && restart_or_timeout |-> buf_clear, "bad start/timeout")
  // only the completing digit is followed by a verdict
  `KCL_ASSERT(a_digit_last, clk_i, rst_ni, out_valid_o && open_digit |-> full_count, "open run on short code")
  `KCL_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result during reset")

endmodule

bind keypad_code_lock kcl_assert_checker u_kcl_checker (.*);

/* verif/kcl_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the keypad code lock: predicts the results of every item
// accepted on the input channel and checks them against the output channel.
// Depends on kcl_pkg only.
module kcl_checker import kcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  kcl_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  kcl_out_t             out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output int                   fails_o,
  output int                   pending_o
);

  localparam int DIG_IDX_W = $clog2(CODE_LENGTH);

  // mirror of the lock state
  logic              entry_on;
  logic [2:0]        held_cnt;
  logic [3:0]        held_digit [CODE_LENGTH];
  logic [IDLE_W-1:0] idle_cnt;
  logic [15:0]       code_r;
  logic [15:0]       tmo_r;

  kcl_out_t lock_reports_q[$];
  int       fail_cnt;

  function automatic kcl_out_t snapshot(kcl_event_e ev);
    kcl_out_t r;
    r.event_res = ev;
    r.shown_digits = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CODE_LENGTH) r.shown_digits[4*(3-i) +: 4] = held_digit[i];
    end
    r.entered_count = held_cnt;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic void clear_held();
    for (int i = 0; i < CODE_LENGTH; i++) held_digit[i] = '0;
    held_cnt = '0;
  endfunction

  function automatic void predict_lock_reports(kcl_in_t item);
    kcl_out_t res [2];
    int       n;
    logic     ok;
    logic [3:0] want;
    n = 0;
    if (item.cmd == CMD_TICK) begin
      if (entry_on) begin
        if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt > {1'b0, tmo_r}) begin
          clear_held();
          entry_on = 1'b0;
          idle_cnt = '0;
          res[n] = snapshot(EV_TIMEOUT);
          n++;
        end
      end
    end else if (item.key_code == KEY_STAR || item.key_code == KEY_HASH) begin
      entry_on = 1'b1;
      clear_held();
      idle_cnt = '0;
      res[n] = snapshot(EV_START);
      n++;
    end else if (item.key_code <= KEY_DIGIT_MAX && entry_on && held_cnt < CODE_LENGTH) begin
      held_digit[held_cnt[DIG_IDX_W-1:0]] = item.key_code;
      held_cnt = held_cnt + 1'b1;
      idle_cnt = '0;
      res[n] = snapshot(EV_DIGIT);
      n++;
      if (held_cnt >= CODE_LENGTH) begin
        ok = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++) begin
          want = (i < 4) ? code_r[4*(3-i) +: 4] : 4'd0;
          if (held_digit[i] != want) ok = 1'b0;
        end
        clear_held();
        entry_on = 1'b0;
        idle_cnt = '0;
        res[n] = snapshot(ok ? EV_OK : EV_BAD);
        n++;
      end
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) lock_reports_q.push_back(res[i]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kcl_out_t want;
    if (!rst_ni) begin
      entry_on = 1'b0;
      idle_cnt = '0;
      clear_held();
      code_r = CODE_RESET;
      tmo_r = TIMEOUT_RESET;
      lock_reports_q.delete();
      fail_cnt = 0;
      fails_o <= 0;
      pending_o <= 0;
    end else begin
      // results leave in the cycle after their item at the earliest, so check before predicting
      if (out_valid_i && out_ready_i) begin
        if (lock_reports_q.size() == 0) begin
          $error("result with no item pending: event_res %0d", out_data_i.event_res);
          fail_cnt++;
        end else begin
          want = lock_reports_q.pop_front();
          check_field("event_res", want.event_res, out_data_i.event_res);
          check_field("shown_digits", want.shown_digits, out_data_i.shown_digits);
          check_field("entered_count", want.entered_count, out_data_i.entered_count);
          check_field("last_of_run", want.last_of_run, out_data_i.last_of_run);
        end
      end
      // an item taken at the same edge as a write still sees the old settings
      if (in_valid_i && in_ready_i) predict_lock_reports(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CODE:    code_r = cfg_data_i;
          CFG_TIMEOUT: tmo_r = cfg_data_i;
          default: ;
        endcase
      end
      fails_o <= fail_cnt;
      pending_o <= lock_reports_q.size();
    end
  end

endmodule

/* verif/keypad_code_lock_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the keypad code lock: drives keys, ticks and register
// writes, and gives the verdict. Depends on kcl_pkg, the block and kcl_checker.
module keypad_code_lock_tb;
  import kcl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [3:0]           KEY_LETTER_A = 4'd12;
  localparam logic [3:0]           KEY_LETTER_B = 4'd13;
  localparam logic [3:0]           KEY_LETTER_C = 4'd14;
  localparam logic [3:0]           KEY_LETTER_D = 4'd15;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  kcl_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  kcl_out_t             out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;

  int          fails;
  int          pending;
  int          sent_cnt;
  bit          idle_en;
  bit          hold_req;
  logic [15:0] code_now;
  logic [15:0] tmo_now;

  keypad_code_lock dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  kcl_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [3:0] key);
    kcl_in_t item;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    item.cmd = cmd;
    item.key_code = key;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic press(input logic [3:0] key);
    send_item(CMD_KEY, key);
  endtask

  // key field is don't-care on a tick, so keep it random
  task automatic tick();
    send_item(CMD_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // an item with no result may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_CODE) code_now = val;
    if (idx == CFG_TIMEOUT) tmo_now = val;
  endtask

  task automatic set_config(input logic [15:0] code, input logic [15:0] tmo, input bit spare);
    wait_idle();
    write_reg(CFG_CODE, code);
    write_reg(CFG_TIMEOUT, tmo);
    if (spare) begin
      write_reg(CFG_SPARE_LO, 16'($urandom));
      write_reg(CFG_SPARE_HI, 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] random_bcd_code();
    logic [15:0] c;
    for (int i = 0; i < 4; i++) c[4*i +: 4] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // one start key and a full code, with ticks, stray keys and restarts between
  task automatic code_entry();
    int         n_ticks;
    bit         aim_ok;
    logic [3:0] d;
    press($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
    aim_ok = $urandom_range(0, 1);
    for (int i = 0; i < CODE_LENGTH; i++) begin
      n_ticks = $urandom_range(0, 2);
      if (tmo_now < 16 && $urandom_range(0, 9) == 0) n_ticks = tmo_now + 1;
      repeat (n_ticks) tick();
      case ($urandom_range(0, 15))
        0: press(4'($urandom_range(KEY_LETTER_A, KEY_LETTER_D)));
        1: press($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
        default: ;
      endcase
      d = (i < 4) ? code_now[4*(3-i) +: 4] : 4'd0;
      if (!aim_ok || d > KEY_DIGIT_MAX || $urandom_range(0, 7) == 0)
        d = 4'($urandom_range(0, 9));
      press(d);
    end
  endtask

  task automatic random_phase(input int n);
    int stop_at;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      else
        code_entry();
    end
  endtask

  initial begin
    logic [3:0] opening [$];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CODE;
    cfg_data_i = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    sent_cnt = 0;
    code_now = CODE_RESET;
    tmo_now = TIMEOUT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: stray keys while idle, a good code, a bad one with a
    // letter inside, a restart mid-entry and every letter
    tick();
    press(4'd0);
    press(KEY_LETTER_A);
    opening = '{KEY_STAR, 4'd1, 4'd2, 4'd3, 4'd4, KEY_HASH, 4'd9, KEY_LETTER_B, 4'd9, 4'd0,
                4'd0, KEY_STAR};
    foreach (opening[i]) press(opening[i]);
    tick();
    press(4'd5);
    opening = '{KEY_HASH, KEY_LETTER_C, KEY_LETTER_D, 4'd1, 4'd2, 4'd3, 4'd4};
    foreach (opening[i]) press(opening[i]);
    random_phase(150);

    // zero timeout: the first tick after a key ends the entry
    set_config(16'h0000, 16'd0, 1'b0);
    random_phase(150);

    set_config(16'h9999, 16'd1, 1'b1);
    random_phase(150);

    // receiver holds off while items keep coming, so the input stalls
    idle_en = 1'b0;
    hold_req = 1'b1;
    random_phase(60);
    idle_en = 1'b1;

    set_config(16'hFFFF, 16'hFFFF, 1'b0);
    random_phase(150);

    // non-BCD nibbles can never match
    set_config(16'h9AF0, 16'd5, 1'b0);
    random_phase(100);

    set_config(random_bcd_code(), 16'($urandom_range(2, 12)), 1'b1);
    random_phase(150);

    set_config(random_bcd_code(), 16'd3, 1'b0);
    idle_en = 1'b0;
    random_phase(200);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
